>>> design/yuy2yv12_pkg.sv
package yuy2yv12_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int COL_BITS    = $clog2(LINE_DEPTH);
   localparam int PAIR_BITS   = COL_BITS + 1;
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int HALF_BITS   = ROW_BITS;
   localparam int DIM_BITS    = 12;
   localparam int CSR_IDX_BITS = 2;
   localparam int ADDR_BITS   = 23;
   localparam int COFF_BITS   = COL_BITS + HALF_BITS;
   localparam int CSIZE_BITS  = PAIR_BITS + HALF_BITS;

   typedef enum logic [1:0] {
      PLANE_LUMA = 2'd0,
      PLANE_V    = 2'd1,
      PLANE_U    = 2'd2
   } plane_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // half of an even dimension, clamped to one and to half of the maximum
   function automatic logic [HALF_BITS-1:0] half_dim(input logic [DIM_BITS-1:0] value,
                                                     input logic [HALF_BITS-1:0] limit);
      logic [HALF_BITS-1:0] half;
      half = value[DIM_BITS-1:1];
      if (half == '0) begin
         half_dim = HALF_BITS'(1);
      end else if (half > limit) begin
         half_dim = limit;
      end else begin
         half_dim = half;
      end
   endfunction

endpackage

>>> design/yuy2yv12_if.sv
interface yuy2yv12_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] first_luma;
   logic [7:0] blue_diff;
   logic [7:0] second_luma;
   logic [7:0] red_diff;

   modport source (output valid, output first_luma, output blue_diff,
                   output second_luma, output red_diff, input ready);
   modport sink (input valid, input first_luma, input blue_diff,
                 input second_luma, input red_diff, output ready);
endinterface

interface yuy2yv12_rsp_if;
   logic                                 valid;
   logic                                 ready;
   yuy2yv12_pkg::plane_type              plane;
   logic [yuy2yv12_pkg::ADDR_BITS-1:0]   address;
   logic [7:0]                           first_byte;
   logic [7:0]                           second_byte;
   logic                                 last_of_run;

   modport source (output valid, output plane, output address, output first_byte,
                   output second_byte, output last_of_run, input ready);
   modport sink (input valid, input plane, input address, input first_byte,
                 input second_byte, input last_of_run, output ready);
endinterface

>>> design/yuy2_to_yv12_converter_unit.sv
// yuy2 to yv12 converter
// req_channel takes one yuy2 macropixel per request (left luma, u, right luma, v)
// in raster order. rsp_channel returns the planar byte writes: every request
// gives a luma pair write; requests on odd rows also give a v-plane write and
// then a u-plane write of the chroma averaged with the row above. last_of_run
// marks the final response of a request.
// csr port: index 0 writes frame width, index 1 frame height (even, clamped
// to 2..2048). a write to either index returns the position to the top left pixel.
// a request's first response passes from the request stage into the response
// register. even-row requests are taken one per cycle while rsp_channel does
// not stall; odd-row requests hold the request stage for their three responses,
// limited by the single response register fed from the one request stage.
// the chroma line store is a 1024 x 16 single-port memory, one access per
// request, so it never limits the rate.
// reset restores 640 x 480 and the top left position; line store contents
// are not cleared since each odd row reads what the even row above wrote.
// when rsp_channel stalls the response register holds, the request stage
// fills, and req_channel.ready drops until a response is taken.
module yuy2_to_yv12_converter_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   yuy2yv12_req_if.sink                               req_channel,
   yuy2yv12_rsp_if.source                             rsp_channel,
   input  logic                                       csr_write_enable,
   input  logic [yuy2yv12_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [yuy2yv12_pkg::DIM_BITS-1:0]          csr_write_data
);

   localparam int COL_BITS   = yuy2yv12_pkg::COL_BITS;
   localparam int PAIR_BITS  = yuy2yv12_pkg::PAIR_BITS;
   localparam int ROW_BITS   = yuy2yv12_pkg::ROW_BITS;
   localparam int HALF_BITS  = yuy2yv12_pkg::HALF_BITS;
   localparam int ADDR_BITS  = yuy2yv12_pkg::ADDR_BITS;
   localparam int COFF_BITS  = yuy2yv12_pkg::COFF_BITS;
   localparam int CSIZE_BITS = yuy2yv12_pkg::CSIZE_BITS;
   localparam int LINE_DEPTH = yuy2yv12_pkg::LINE_DEPTH;
   localparam logic [HALF_BITS-1:0] HALF_W_MAX = HALF_BITS'(yuy2yv12_pkg::MAX_WIDTH / 2);
   localparam logic [HALF_BITS-1:0] HALF_H_MAX = HALF_BITS'(yuy2yv12_pkg::MAX_HEIGHT / 2);

   // geometry
   logic [PAIR_BITS-1:0]  pairs_ff;
   logic [HALF_BITS-1:0]  half_h_ff;
   logic [CSIZE_BITS-1:0] csize_ff;

   // position
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ADDR_BITS-1:0]  luma_addr_ff;
   logic [COFF_BITS-1:0]  coff_ff;

   // line store
   logic [15:0]           line_mem [LINE_DEPTH];
   logic [15:0]           line_rd_ff;

   // request stage
   logic                     s1_valid_ff;
   yuy2yv12_pkg::plane_type  s1_phase_ff;
   logic                     s1_odd_ff;
   logic [7:0]               s1_y0_ff;
   logic [7:0]               s1_y1_ff;
   logic [7:0]               s1_u_ff;
   logic [7:0]               s1_v_ff;
   logic [ADDR_BITS-1:0]     s1_luma_addr_ff;
   logic [COFF_BITS-1:0]     s1_coff_ff;

   // response register
   logic                     rsp_valid_ff;
   yuy2yv12_pkg::plane_type  rsp_plane_ff;
   logic [ADDR_BITS-1:0]     rsp_addr_ff;
   logic [7:0]               rsp_first_ff;
   logic [7:0]               rsp_second_ff;
   logic                     rsp_last_ff;

   logic                     accept;
   logic                     odd_row;
   logic                     last_col;
   logic                     last_row;
   logic                     out_load;
   logic                     s1_done;
   logic [8:0]               v_sum;
   logic [8:0]               u_sum;
   logic [ADDR_BITS-1:0]     v_addr;
   logic [ADDR_BITS-1:0]     u_addr;
   yuy2yv12_pkg::plane_type  res_plane_in;
   logic [ADDR_BITS-1:0]     res_addr_in;
   logic [7:0]               res_first_in;
   logic [7:0]               res_second_in;
   logic                     res_last_in;
   yuy2yv12_pkg::plane_type  s1_phase_in;

   assign odd_row  = row_ff[0];
   assign last_col = (col_ff == COL_BITS'(pairs_ff - PAIR_BITS'(1)));
   assign last_row = (row_ff == ROW_BITS'({half_h_ff, 1'b0} - (HALF_BITS + 1)'(1)));

   assign out_load = s1_valid_ff && (!rsp_valid_ff || rsp_channel.ready);
   assign s1_done  = out_load && res_last_in;
   assign accept   = req_channel.valid && req_channel.ready;
   assign req_channel.ready = !s1_valid_ff || s1_done;

   assign v_sum  = {1'b0, line_rd_ff[7:0]} + {1'b0, s1_v_ff};
   assign u_sum  = {1'b0, line_rd_ff[15:8]} + {1'b0, s1_u_ff};
   assign v_addr = ADDR_BITS'({csize_ff, 2'b00}) + ADDR_BITS'(s1_coff_ff);
   assign u_addr = v_addr + ADDR_BITS'(csize_ff);

   always_comb begin
      res_plane_in  = yuy2yv12_pkg::PLANE_LUMA;
      res_addr_in   = s1_luma_addr_ff;
      res_first_in  = s1_y0_ff;
      res_second_in = s1_y1_ff;
      res_last_in   = !s1_odd_ff;
      s1_phase_in   = yuy2yv12_pkg::PLANE_V;
      unique case (s1_phase_ff)
         yuy2yv12_pkg::PLANE_V: begin
            res_plane_in  = yuy2yv12_pkg::PLANE_V;
            res_addr_in   = v_addr;
            res_first_in  = v_sum[8:1];
            res_second_in = 8'd0;
            res_last_in   = 1'b0;
            s1_phase_in   = yuy2yv12_pkg::PLANE_U;
         end
         yuy2yv12_pkg::PLANE_U: begin
            res_plane_in  = yuy2yv12_pkg::PLANE_U;
            res_addr_in   = u_addr;
            res_first_in  = u_sum[8:1];
            res_second_in = 8'd0;
            res_last_in   = 1'b1;
            s1_phase_in   = yuy2yv12_pkg::PLANE_LUMA;
         end
         default: begin
         end
      endcase
   end

   // geometry and position
   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_ff     <= PAIR_BITS'(320);
         half_h_ff    <= HALF_BITS'(240);
         col_ff       <= '0;
         row_ff       <= '0;
         luma_addr_ff <= '0;
         coff_ff      <= '0;
      end else if (csr_write_enable && (csr_index == yuy2yv12_pkg::CSR_FRAME_WIDTH ||
                                        csr_index == yuy2yv12_pkg::CSR_FRAME_HEIGHT)) begin
         if (csr_index == yuy2yv12_pkg::CSR_FRAME_WIDTH) begin
            pairs_ff <= PAIR_BITS'(yuy2yv12_pkg::half_dim(csr_write_data, HALF_W_MAX));
         end else begin
            half_h_ff <= yuy2yv12_pkg::half_dim(csr_write_data, HALF_H_MAX);
         end
         col_ff       <= '0;
         row_ff       <= '0;
         luma_addr_ff <= '0;
         coff_ff      <= '0;
      end else if (accept) begin
         if (last_col && last_row) begin
            col_ff       <= '0;
            row_ff       <= '0;
            luma_addr_ff <= '0;
            coff_ff      <= '0;
         end else begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= row_ff + ROW_BITS'(1);
            end else begin
               col_ff <= col_ff + COL_BITS'(1);
            end
            luma_addr_ff <= luma_addr_ff + ADDR_BITS'(2);
            coff_ff      <= coff_ff + COFF_BITS'(odd_row);
         end
      end
   end

   // chroma plane size, registered from the registered frame geometry
   always_ff @(posedge clock) begin
      csize_ff <= CSIZE_BITS'(pairs_ff) * CSIZE_BITS'(half_h_ff);
   end

   // line store: even rows write, odd rows read
   always_ff @(posedge clock) begin
      if (accept) begin
         if (odd_row) begin
            line_rd_ff <= line_mem[col_ff];
         end else begin
            line_mem[col_ff] <= {req_channel.blue_diff, req_channel.red_diff};
         end
      end
   end

   // request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_phase_ff <= yuy2yv12_pkg::PLANE_LUMA;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         s1_phase_ff <= yuy2yv12_pkg::PLANE_LUMA;
      end else if (s1_done) begin
         s1_valid_ff <= 1'b0;
      end else if (out_load) begin
         s1_phase_ff <= s1_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_odd_ff       <= odd_row;
         s1_y0_ff        <= req_channel.first_luma;
         s1_y1_ff        <= req_channel.second_luma;
         s1_u_ff         <= req_channel.blue_diff;
         s1_v_ff         <= req_channel.red_diff;
         s1_luma_addr_ff <= luma_addr_ff;
         s1_coff_ff      <= coff_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_plane_ff  <= res_plane_in;
         rsp_addr_ff   <= res_addr_in;
         rsp_first_ff  <= res_first_in;
         rsp_second_ff <= res_second_in;
         rsp_last_ff   <= res_last_in;
      end
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.plane       = rsp_plane_ff;
   assign rsp_channel.address     = rsp_addr_ff;
   assign rsp_channel.first_byte  = rsp_first_ff;
   assign rsp_channel.second_byte = rsp_second_ff;
   assign rsp_channel.last_of_run = rsp_last_ff;

endmodule

>>> tb/sv/yuy2_to_yv12_converter_unit_test.sv
`timescale 1ns / 100ps

module yuy2_to_yv12_converter_unit_test;

   localparam int ADDR_BITS    = yuy2yv12_pkg::ADDR_BITS;
   localparam int CSR_IDX_BITS = yuy2yv12_pkg::CSR_IDX_BITS;
   localparam int DIM_BITS     = yuy2yv12_pkg::DIM_BITS;
   localparam int LINE_DEPTH   = yuy2yv12_pkg::LINE_DEPTH;
   localparam int MAX_WIDTH    = yuy2yv12_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT   = yuy2yv12_pkg::MAX_HEIGHT;
   localparam yuy2yv12_pkg::plane_type PLANE_LUMA = yuy2yv12_pkg::PLANE_LUMA;
   localparam yuy2yv12_pkg::plane_type PLANE_V    = yuy2yv12_pkg::PLANE_V;
   localparam yuy2yv12_pkg::plane_type PLANE_U    = yuy2yv12_pkg::PLANE_U;
   localparam yuy2yv12_pkg::csr_index_type CSR_FRAME_WIDTH  =
      yuy2yv12_pkg::CSR_FRAME_WIDTH;
   localparam yuy2yv12_pkg::csr_index_type CSR_FRAME_HEIGHT =
      yuy2yv12_pkg::CSR_FRAME_HEIGHT;

   typedef struct packed {
      logic [7:0] first_luma;
      logic [7:0] blue_diff;
      logic [7:0] second_luma;
      logic [7:0] red_diff;
   } macropixel_type;

   typedef struct packed {
      yuy2yv12_pkg::plane_type plane;
      logic [ADDR_BITS-1:0]    address;
      logic [7:0]              first_byte;
      logic [7:0]              second_byte;
      logic                    last_of_run;
   } plane_write_type;

   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_PIXEL_KNOWN,
      STEP_CSR
   } step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      logic [CSR_IDX_BITS-1:0] csr_index;
      logic [DIM_BITS-1:0]     csr_value;
      macropixel_type          pixel;
      plane_write_type         known_write;
   } step_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_LOW  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_HIGH = 2'd3;
   localparam macropixel_type  NO_PIXEL = '0;
   localparam plane_write_type NO_WRITE = '0;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS     = 120;
   localparam int IDLE_GAP_MAX     = 16;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0]     csr_write_data;

   yuy2yv12_req_if req_bus();
   yuy2yv12_rsp_if rsp_bus();

   yuy2_to_yv12_converter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_bus),
      .rsp_channel      (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the converter state
   logic [DIM_BITS-1:0] frame_width_reg  = DIM_BITS'(640);
   logic [DIM_BITS-1:0] frame_height_reg = DIM_BITS'(480);
   logic [15:0]         chroma_above [0:LINE_DEPTH-1];
   int                  column_pos = 0;
   int                  row_pos    = 0;

   plane_write_type pending_writes [$];
   int              fault_count   = 0;
   int              req_gap_max   = IDLE_GAP_MAX;
   int              rsp_stall_max = IDLE_GAP_MAX;
   bit              long_hold_pending = 1'b0;

   step_type directed_steps [35] = '{
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h00, 8'h00, 8'h00, 8'h00},
        '{PLANE_LUMA, 23'd0, 8'h00, 8'h00, 1'b1}},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{PLANE_LUMA, 23'd2, 8'hFF, 8'hFF, 1'b1}},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'hA5, 8'h5A, 8'h3C, 8'hC3},
        '{PLANE_LUMA, 23'd4, 8'hA5, 8'h3C, 1'b1}},
      '{STEP_CSR, CSR_UNMAPPED_LOW, 12'hFFF, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h12, 8'h34, 8'h56, 8'h78},
        '{PLANE_LUMA, 23'd6, 8'h12, 8'h56, 1'b1}},
      '{STEP_CSR, CSR_UNMAPPED_HIGH, 12'h000, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h9A, 8'hBC, 8'hDE, 8'hF0},
        '{PLANE_LUMA, 23'd8, 8'h9A, 8'hDE, 1'b1}},
      // below-two dimensions, one macropixel per row
      '{STEP_CSR, CSR_FRAME_WIDTH, 12'h000, NO_PIXEL, NO_WRITE},
      '{STEP_CSR, CSR_FRAME_HEIGHT, 12'h001, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h10, 8'hFF, 8'h20, 8'hFF},
        '{PLANE_LUMA, 23'd0, 8'h10, 8'h20, 1'b1}},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h30, 8'hFF, 8'h40, 8'hFF}, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h50, 8'h00, 8'h60, 8'h00},
        '{PLANE_LUMA, 23'd0, 8'h50, 8'h60, 1'b1}},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h70, 8'hFF, 8'h80, 8'hFE}, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h01, 8'h01, 8'h02, 8'h01},
        '{PLANE_LUMA, 23'd0, 8'h01, 8'h02, 1'b1}},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h03, 8'h00, 8'h04, 8'h00}, NO_WRITE},
      // saturated width, odd height
      '{STEP_CSR, CSR_FRAME_WIDTH, 12'hFFF, NO_PIXEL, NO_WRITE},
      '{STEP_CSR, CSR_FRAME_HEIGHT, 12'h003, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'h55, 8'hAA, 8'hAA, 8'h55},
        '{PLANE_LUMA, 23'd0, 8'h55, 8'hAA, 1'b1}},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'hAA, 8'h55, 8'h55, 8'hAA},
        '{PLANE_LUMA, 23'd2, 8'hAA, 8'h55, 1'b1}},
      // odd width, saturated height
      '{STEP_CSR, CSR_FRAME_WIDTH, 12'h005, NO_PIXEL, NO_WRITE},
      '{STEP_CSR, CSR_FRAME_HEIGHT, 12'hFFF, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h20, 8'h80, 8'h21, 8'h7F}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h22, 8'h81, 8'h23, 8'h7E}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h24, 8'h7F, 8'h25, 8'h80}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'h26, 8'h7E, 8'h27, 8'h81}, NO_WRITE},
      // largest frame
      '{STEP_CSR, CSR_FRAME_WIDTH, 12'h800, NO_PIXEL, NO_WRITE},
      '{STEP_CSR, CSR_FRAME_HEIGHT, 12'h800, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'hC0, 8'h3F, 8'hC1, 8'h3E},
        '{PLANE_LUMA, 23'd0, 8'hC0, 8'hC1, 1'b1}},
      '{STEP_PIXEL_KNOWN, CSR_FRAME_WIDTH, 12'h000, '{8'hC2, 8'h3D, 8'hC3, 8'h3C},
        '{PLANE_LUMA, 23'd2, 8'hC2, 8'hC3, 1'b1}},
      // 2 x 4 frame, two chroma rows
      '{STEP_CSR, CSR_FRAME_WIDTH, 12'h002, NO_PIXEL, NO_WRITE},
      '{STEP_CSR, CSR_FRAME_HEIGHT, 12'h004, NO_PIXEL, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'hE0, 8'hF0, 8'hE1, 8'h0F}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'hE2, 8'h0F, 8'hE3, 8'hF0}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'hE4, 8'h00, 8'hE5, 8'hFF}, NO_WRITE},
      '{STEP_PIXEL, CSR_FRAME_WIDTH, 12'h000, '{8'hE6, 8'hFF, 8'hE7, 8'h00}, NO_WRITE}
   };

   always #10 clock = ~clock;

   function automatic int effective_dim(input logic [DIM_BITS-1:0] raw, input int limit);
      int dim;
      dim = int'({raw[DIM_BITS-1:1], 1'b0});
      if (dim < 2) begin
         dim = 2;
      end
      if (dim > limit) begin
         dim = limit;
      end
      return dim;
   endfunction

   // queues the plane writes of one macropixel and advances the raster position
   function automatic int convert_macropixel(input macropixel_type px);
      int              w;
      int              h;
      int              pairs;
      int              coff;
      int              v_sum;
      int              u_sum;
      logic [15:0]     above;
      plane_write_type wr;
      int              count;
      w = effective_dim(frame_width_reg, MAX_WIDTH);
      h = effective_dim(frame_height_reg, MAX_HEIGHT);
      pairs = w / 2;
      wr = '{PLANE_LUMA, ADDR_BITS'(row_pos * w + 2 * column_pos), px.first_luma,
             px.second_luma, 1'b0};
      if (row_pos % 2 == 0) begin
         chroma_above[column_pos] = {px.blue_diff, px.red_diff};
         wr.last_of_run = 1'b1;
         pending_writes.push_back(wr);
         count = 1;
      end else begin
         above = chroma_above[column_pos];
         pending_writes.push_back(wr);
         coff = (row_pos / 2) * pairs + column_pos;
         v_sum = int'(above[7:0]) + int'(px.red_diff);
         u_sum = int'(above[15:8]) + int'(px.blue_diff);
         wr = '{PLANE_V, ADDR_BITS'(w * h + coff), 8'(v_sum >> 1), 8'h00, 1'b0};
         pending_writes.push_back(wr);
         wr = '{PLANE_U, ADDR_BITS'(w * h + pairs * (h / 2) + coff), 8'(u_sum >> 1),
                8'h00, 1'b1};
         pending_writes.push_back(wr);
         count = 3;
      end
      column_pos++;
      if (column_pos >= pairs) begin
         column_pos = 0;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
         end
      end
      return count;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_pixel(input macropixel_type px, input bit known,
                             input plane_write_type known_write);
      int gap;
      int count;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.first_luma  <= px.first_luma;
      req_bus.blue_diff   <= px.blue_diff;
      req_bus.second_luma <= px.second_luma;
      req_bus.red_diff    <= px.red_diff;
      do @(posedge clock); while (!req_bus.ready);
      count = convert_macropixel(px);
      if (known) begin
         repeat (count) void'(pending_writes.pop_back());
         pending_writes.push_back(known_write);
      end
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) begin
         frame_width_reg = value;
         column_pos = 0;
         row_pos = 0;
      end else if (idx == CSR_FRAME_HEIGHT) begin
         frame_height_reg = value;
         column_pos = 0;
         row_pos = 0;
      end
      @(negedge clock);
   endtask

   initial begin : response_sink
      int              stall;
      plane_write_type want;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = long_hold_pending ? LONG_HOLD_CYCLES : $urandom_range(0, rsp_stall_max);
         long_hold_pending = 1'b0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_writes.size() == 0) begin
            $error("unexpected response: plane %0d address %0d", rsp_bus.plane,
                   rsp_bus.address);
            fault_count++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_bus.plane !== want.plane) begin
               $error("plane: expected %0d, actual %0d", want.plane, rsp_bus.plane);
               fault_count++;
            end
            if (rsp_bus.address !== want.address) begin
               $error("address: expected %0d, actual %0d", want.address, rsp_bus.address);
               fault_count++;
            end
            if (rsp_bus.first_byte !== want.first_byte) begin
               $error("first_byte: expected %0h, actual %0h", want.first_byte,
                      rsp_bus.first_byte);
               fault_count++;
            end
            if (rsp_bus.second_byte !== want.second_byte) begin
               $error("second_byte: expected %0h, actual %0h", want.second_byte,
                      rsp_bus.second_byte);
               fault_count++;
            end
            if (rsp_bus.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                      rsp_bus.last_of_run);
               fault_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                  phase;
      int                  count;
      int                  random_items;
      logic [DIM_BITS-1:0] width_raw;
      logic [DIM_BITS-1:0] height_raw;
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = CSR_FRAME_WIDTH;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.first_luma  = '0;
      req_bus.blue_diff   = '0;
      req_bus.second_luma = '0;
      req_bus.red_diff    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_CSR: begin
               wait_for_idle();
               write_csr(directed_steps[i].csr_index, directed_steps[i].csr_value);
            end
            STEP_PIXEL: begin
               send_pixel(directed_steps[i].pixel, 1'b0, NO_WRITE);
            end
            default: begin
               send_pixel(directed_steps[i].pixel, 1'b1, directed_steps[i].known_write);
            end
         endcase
      end

      // random frames, mostly small so that rows and frames wrap often
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         wait_for_idle();
         width_raw = ($urandom_range(0, 7) == 0) ? DIM_BITS'($urandom_range(0, 4095))
                                                 : DIM_BITS'($urandom_range(0, 24));
         height_raw = ($urandom_range(0, 7) == 0) ? DIM_BITS'($urandom_range(0, 4095))
                                                  : DIM_BITS'($urandom_range(0, 12));
         write_csr(CSR_FRAME_WIDTH, width_raw);
         write_csr(CSR_FRAME_HEIGHT, height_raw);
         req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : IDLE_GAP_MAX;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_GAP_MAX;
         if (phase == 1) begin
            req_gap_max = 0;
            long_hold_pending = 1'b1;
         end
         count = $urandom_range(16, 40);
         for (int i = 0; i < count; i++) begin
            if (i == count / 2 && $urandom_range(0, 1) == 1) begin
               wait_for_idle();
            end
            send_pixel(macropixel_type'($urandom), 1'b0, NO_WRITE);
         end
         random_items += count;
         phase++;
      end

      wait_for_idle();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
design/yuy2yv12_pkg.sv
design/yuy2yv12_if.sv
design/yuy2_to_yv12_converter_unit.sv
tb/sv/yuy2_to_yv12_converter_unit_test.sv
